>>> rtl/slcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  typedef logic [1:0] event_t;

  localparam event_t EV_DATA    = 2'd0;
  localparam event_t EV_GOOD    = 2'd1;
  localparam event_t EV_BAD     = 2'd2;
  localparam event_t EV_TOOLONG = 2'd3;

  localparam logic [1:0] CFG_SYNC_WORD = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd1;

  localparam logic [31:0] SYNC_WORD_RST = 32'h55AA55AA;
  localparam logic [7:0]  MAX_LEN_RST   = 8'd128;

  localparam int unsigned FRAME_LIMIT    = 256;
  localparam int unsigned FRAME_OVERHEAD = 10;

  typedef struct packed {
    event_t      kind;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [15:0] frame_len;
    logic [31:0] computed_sum;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sync_length_checksum_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sync word / length-prefixed frame parser with a 32-bit additive checksum.
// One received byte is taken per cycle on in_*: the block hunts for the sync
// word (first byte in the low bits), reads a little-endian 16-bit length,
// passes each payload byte out with its index, then checks four
// little-endian checksum bytes against the sum of the length and payload
// bytes. Each byte updates the state registers as it is taken, and any result
// is registered into an output register backed by one skid entry: with
// out_tready high, bytes flow at one per cycle; when a result is held back,
// the next one fills the skid entry and in_tready drops until the skid entry
// has moved on.
// Registers via cfg_*: index 0 sync word, index 1 maximum payload length.
module sync_length_checksum_deframer_top #(
  parameter int unsigned MAX_PAYLOAD = 128
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  // [7:0] data_byte, [14:8] byte_index, [30:15] frame_len,
  // [62:31] computed_sum, [63] zero
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import slcd_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CSUM = 2'd3;

  localparam logic [16:0] MaxLen   = 17'(MAX_PAYLOAD);
  localparam logic [16:0] FrameMax = 17'(FRAME_LIMIT - FRAME_OVERHEAD);

  logic [31:0] sync_word_r;
  logic [7:0]  max_len_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] rsum_r, rsum_nxt;

  result_t     res;
  logic        res_valid;

  result_t     main_r, skid_r;
  logic        main_valid_r, skid_valid_r;

  logic        accept, pop;
  logic [31:0] shifted;
  logic [2:0]  fill_inc;
  logic [15:0] len_full;
  logic [7:0]  cnt_inc;
  logic        too_long;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign pop       = main_valid_r && out_tready;

  assign shifted  = {in_tdata, window_r[31:8]};
  assign fill_inc = (fill_r < 3'd4) ? fill_r + 3'd1 : fill_r;
  assign len_full = {in_tdata, len_r[7:0]};
  assign cnt_inc  = cnt_r + 8'd1;
  assign too_long = ({1'b0, len_full} > {9'd0, max_len_r}) || ({1'b0, len_full} > MaxLen)
                    || ({1'b0, len_full} > FrameMax);

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    rsum_nxt   = rsum_r;
    res_valid  = 1'b0;
    res.kind         = EV_DATA;
    res.data_byte    = '0;
    res.byte_index   = '0;
    res.frame_len    = len_r;
    res.computed_sum = sum_r;
    unique case (phase_r)
      PH_HUNT: begin
        window_nxt = shifted;
        fill_nxt   = fill_inc;
        if (fill_inc == 3'd4 && shifted == sync_word_r) begin
          phase_nxt  = PH_LEN;
          window_nxt = '0;
          fill_nxt   = '0;
          cnt_nxt    = '0;
          len_nxt    = '0;
          sum_nxt    = '0;
        end
      end
      PH_LEN: begin
        sum_nxt = sum_r + {24'd0, in_tdata};
        if (cnt_r == 8'd0) begin
          len_nxt = {8'd0, in_tdata};
          cnt_nxt = 8'd1;
        end else begin
          len_nxt = len_full;
          cnt_nxt = '0;
          res.frame_len    = len_full;
          res.computed_sum = sum_nxt;
          if (too_long) begin
            res_valid  = 1'b1;
            res.kind   = EV_TOOLONG;
            phase_nxt  = PH_HUNT;
            window_nxt = '0;
            fill_nxt   = '0;
          end else begin
            phase_nxt = (len_full == 16'd0) ? PH_CSUM : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        sum_nxt          = sum_r + {24'd0, in_tdata};
        res_valid        = 1'b1;
        res.data_byte    = in_tdata;
        res.byte_index   = cnt_r[6:0];
        res.computed_sum = sum_nxt;
        cnt_nxt          = cnt_inc;
        if ({8'd0, cnt_inc} >= len_r) begin
          cnt_nxt   = '0;
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        case (cnt_r[1:0])
          2'd0:    rsum_nxt[7:0]   = in_tdata;
          2'd1:    rsum_nxt[15:8]  = in_tdata;
          2'd2:    rsum_nxt[23:16] = in_tdata;
          default: rsum_nxt[31:24] = in_tdata;
        endcase
        cnt_nxt = cnt_inc;
        if (cnt_r[1:0] == 2'd3) begin
          res_valid  = 1'b1;
          res.kind   = (rsum_nxt == sum_r) ? EV_GOOD : EV_BAD;
          phase_nxt  = PH_HUNT;
          window_nxt = '0;
          fill_nxt   = '0;
          cnt_nxt    = '0;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_WORD_RST;
      max_len_r   <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_WORD: sync_word_r <= cfg_data;
        CFG_MAX_LEN:   max_len_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= '0;
      fill_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
      rsum_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      rsum_r   <= rsum_nxt;
    end
  end

  // output buffer: main register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop && skid_valid_r) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (accept && res_valid) begin
        if (!main_valid_r || pop) begin
          main_r       <= res;
          main_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        main_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = main_valid_r;
  assign out_tuser  = main_r.kind;
  assign out_tdata  = {1'b0, main_r.computed_sum, main_r.frame_len, main_r.byte_index,
                       main_r.data_byte};

endmodule

`default_nettype wire
